@@ rtl/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, constants and helper functions for the quaternion to Euler
// angle pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CORDIC_STAGES_DEF = 18;
  localparam int ATAN_TAB_LEN      = 32;

  localparam int NUM_RATIOS = 5;
  localparam int QUO_W      = 31;   // quotient magnitude bits, value <= 2^30
  localparam int REM_W      = 34;
  localparam int S_W        = 33;
  localparam int ROOT_W     = 31;
  localparam int RAD_W      = 61;
  localparam int VEC_W      = 34;
  localparam int ANG_W      = 29;
  localparam int ANG_FRAC   = 16;
  localparam int NUM_VECS   = 3;

  // ratio slots in the divider chain
  localparam int RAT_YAW_N = 0;
  localparam int RAT_YAW_D = 1;
  localparam int RAT_TAN_N = 2;
  localparam int RAT_TAN_D = 3;
  localparam int RAT_SIN_N = 4;

  // vector slots in the cordic chain
  localparam int VEC_YAW = 0;
  localparam int VEC_TAN = 1;
  localparam int VEC_SIN = 2;

  // configuration register indexes
  localparam logic REG_USE_Y_AXIS  = 1'b0;
  localparam logic REG_INVERT_ROLL = 1'b1;

  localparam logic signed [31:0]    ONE_Q30      = 32'sd1073741824;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 29'sd58982400;  // 900 << 16
  localparam logic signed [11:0]    TENTHS_MAX   = 12'sd1800;
  localparam logic signed [12:0]    HEADING_WRAP = 13'sd3600;

  typedef struct packed {
    logic                      valid;
    logic [S_W-1:0]            s;
    logic [NUM_RATIOS-1:0]     neg;
    logic [NUM_RATIOS-1:0][REM_W-1:0] rem;
    logic [NUM_RATIOS-1:0][QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic                      valid;
    logic                      degen;
    logic signed [31:0]        yaw_y;
    logic signed [31:0]        yaw_x;
    logic signed [31:0]        tan_y;
    logic signed [31:0]        tan_x;
    logic signed [31:0]        sin_t;
    logic [RAD_W-1:0]          rem;
    logic [ROOT_W-1:0]         root;
  } sqrt_t;

  typedef struct packed {
    logic signed [VEC_W-1:0]   x;
    logic signed [VEC_W-1:0]   y;
    logic signed [ANG_W-1:0]   ang;
    logic                      zero;
  } vec_t;

  typedef struct packed {
    logic                      valid;
    logic                      degen;
    vec_t [NUM_VECS-1:0]       vec;
  } cordic_t;

  // atan(2^-i) in 1/65536 tenth-degree units
  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 29'sd29491200;
      1:  v = 29'sd17409672;
      2:  v = 29'sd9198793;
      3:  v = 29'sd4669451;
      4:  v = 29'sd2343786;
      5:  v = 29'sd1173036;
      6:  v = 29'sd586661;
      7:  v = 29'sd293348;
      8:  v = 29'sd146676;
      9:  v = 29'sd73339;
      10: v = 29'sd36669;
      11: v = 29'sd18335;
      12: v = 29'sd9167;
      13: v = 29'sd4584;
      14: v = 29'sd2292;
      15: v = 29'sd1146;
      16: v = 29'sd573;
      17: v = 29'sd286;
      18: v = 29'sd143;
      19: v = 29'sd72;
      20: v = 29'sd36;
      21: v = 29'sd18;
      22: v = 29'sd9;
      23: v = 29'sd4;
      24: v = 29'sd2;
      25: v = 29'sd1;
      26: v = 29'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // truncate toward zero to tenths and clamp to +-1800
  function automatic logic signed [11:0] to_tenths(input logic signed [ANG_W-1:0] a);
    logic [ANG_W-1:0] mag;
    logic [12:0]      t;
    logic [11:0]      c;
    mag = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
    t   = mag[ANG_W-1:ANG_FRAC];
    c   = (t > 13'(TENTHS_MAX)) ? 12'(TENTHS_MAX) : t[11:0];
    return a[ANG_W-1] ? $signed(-c) : $signed(c);
  endfunction

endpackage

@@ rtl/q2e_div_cell.sv @@
// ----------------------------------------------------------------------------
// q2e_div_cell
// One restoring-division step: produces one quotient bit for each of the
// five ratio terms and hands the remainders to the next cell.
// ----------------------------------------------------------------------------
module q2e_div_cell #(
  parameter bit SHIFT_IN = 1'b1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  q2e_pkg::div_t  din,
  output q2e_pkg::div_t  dout
);

  q2e_pkg::div_t             d_next;
  logic [q2e_pkg::REM_W-1:0] r [q2e_pkg::NUM_RATIOS];
  logic [q2e_pkg::REM_W-1:0] s_ext;

  assign s_ext = q2e_pkg::REM_W'(din.s);

  always_comb begin
    d_next = din;
    for (int j = 0; j < q2e_pkg::NUM_RATIOS; j++) begin
      r[j] = SHIFT_IN ? {din.rem[j][q2e_pkg::REM_W-2:0], 1'b0} : din.rem[j];
      if (r[j] >= s_ext) begin
        d_next.rem[j] = r[j] - s_ext;
        d_next.quo[j] = {din.quo[j][q2e_pkg::QUO_W-2:0], 1'b1};
      end else begin
        d_next.rem[j] = r[j];
        d_next.quo[j] = {din.quo[j][q2e_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= d_next;
    end
  end

endmodule

@@ rtl/q2e_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One digit of the integer square root: decides root bit K and carries the
// angle operands along.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  q2e_pkg::sqrt_t  din,
  output q2e_pkg::sqrt_t  dout
);

  localparam int TERM_W = q2e_pkg::RAD_W + 2;

  q2e_pkg::sqrt_t  d_next;
  logic [TERM_W-1:0] term;
  logic [TERM_W-1:0] rem_ext;

  // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
  assign term    = (TERM_W'(din.root) << (K + 1)) | (TERM_W'(1) << (2 * K));
  assign rem_ext = TERM_W'(din.rem);

  always_comb begin
    d_next = din;
    if (rem_ext >= term) begin
      d_next.rem  = q2e_pkg::RAD_W'(rem_ext - term);
      d_next.root = din.root | (q2e_pkg::ROOT_W'(1) << K);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= d_next;
    end
  end

endmodule

@@ rtl/q2e_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring micro-rotation for the yaw, atan2 and asin vectors.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
  parameter int I = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  q2e_pkg::cordic_t  din,
  output q2e_pkg::cordic_t  dout
);

  localparam logic signed [q2e_pkg::ANG_W-1:0] ATAN_I = q2e_pkg::atan_entry(I);

  q2e_pkg::cordic_t              d_next;
  logic signed [q2e_pkg::VEC_W-1:0] xs [q2e_pkg::NUM_VECS];
  logic signed [q2e_pkg::VEC_W-1:0] ys [q2e_pkg::NUM_VECS];

  always_comb begin
    d_next = din;
    for (int j = 0; j < q2e_pkg::NUM_VECS; j++) begin
      xs[j] = $signed(din.vec[j].x) >>> I;
      ys[j] = $signed(din.vec[j].y) >>> I;
      // y >= 0 rotates down, so atan2(0, negative) lands on +180
      if (!din.vec[j].y[q2e_pkg::VEC_W-1]) begin
        d_next.vec[j].x   = din.vec[j].x + ys[j];
        d_next.vec[j].y   = din.vec[j].y - xs[j];
        d_next.vec[j].ang = din.vec[j].ang + ATAN_I;
      end else begin
        d_next.vec[j].x   = din.vec[j].x - ys[j];
        d_next.vec[j].y   = din.vec[j].y + xs[j];
        d_next.vec[j].ang = din.vec[j].ang - ATAN_I;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= d_next;
    end
  end

endmodule

@@ rtl/quaternion_to_euler_angles.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Z-Y-X Euler angles (heading, pitch, roll in tenths of a degree) from a
// signed Q14 orientation quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one quaternion per transfer; m_axis returns one result per
//   input in the same order. cfg_we/cfg_index/cfg_data write use_y_axis
//   (index 0) and invert_roll (index 1), bit 0 of the data only; write them
//   while the pipeline is empty.
// Pipeline: from input transfer to m_axis_tvalid the data passes the product
//   and sum registers, 31 divider cells, the sign fix-up and squaring
//   registers, the radicand register, 31 square-root cells, the quadrant
//   pre-rotation register, CORDIC_STAGES rotation cells and the output
//   register.
// Throughput: one quaternion per cycle while m_axis is not stalled; every cell
//   hands its data on each cycle the pipeline advances.
// Reset clears the valid bits of every cell and the output, sets
//   use_y_axis to 0 and invert_roll to 1.
// When m_axis_tready is low with a result waiting, the whole chain holds and
//   s_axis_tready drops; an empty output register lets the chain advance.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [0:0]  cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // heading_tenths, pitch_tenths, roll_tenths, pad
  output logic [0:0]  m_axis_tuser    // degenerate
);

  localparam int DIV_CELLS  = q2e_pkg::QUO_W;
  localparam int SQRT_CELLS = q2e_pkg::ROOT_W;

  logic en;
  logic use_y_axis;
  logic invert_roll;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      use_y_axis  <= 1'b0;
      invert_roll <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        q2e_pkg::REG_USE_Y_AXIS:  use_y_axis  <= cfg_data[0];
        q2e_pkg::REG_INVERT_ROLL: invert_roll <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- products ----------------
  logic signed [15:0] qw, qx, qy, qz;
  logic               p_valid;
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_wz, p_xy, p_wx, p_yz, p_wy, p_zx;

  assign qw = $signed(s_axis_tdata[15:0]);
  assign qx = $signed(s_axis_tdata[31:16]);
  assign qy = $signed(s_axis_tdata[47:32]);
  assign qz = $signed(s_axis_tdata[63:48]);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ww <= qw * qw;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
    end
  end

  // ---------------- sums, load divider ----------------
  q2e_pkg::div_t       div_pipe [DIV_CELLS+1];
  q2e_pkg::div_t       div_load;
  logic signed [34:0]  sum_s;
  logic signed [34:0]  num [q2e_pkg::NUM_RATIOS];
  logic signed [34:0]  num_mag [q2e_pkg::NUM_RATIOS];

  always_comb begin
    sum_s = 35'(p_ww) + 35'(p_xx) + 35'(p_yy) + 35'(p_zz);
    num[q2e_pkg::RAT_YAW_N] = (35'(p_wz) + 35'(p_xy)) <<< 1;
    num[q2e_pkg::RAT_YAW_D] = 35'(p_ww) + 35'(p_xx) - 35'(p_yy) - 35'(p_zz);
    num[q2e_pkg::RAT_TAN_N] = (35'(p_wx) + 35'(p_yz)) <<< 1;
    num[q2e_pkg::RAT_TAN_D] = 35'(p_ww) + 35'(p_zz) - 35'(p_xx) - 35'(p_yy);
    num[q2e_pkg::RAT_SIN_N] = (35'(p_wy) - 35'(p_zx)) <<< 1;
    div_load       = '0;
    div_load.valid = p_valid;
    div_load.s     = sum_s[q2e_pkg::S_W-1:0];
    for (int j = 0; j < q2e_pkg::NUM_RATIOS; j++) begin
      num_mag[j]        = num[j][34] ? -num[j] : num[j];
      div_load.neg[j]   = num[j][34];
      div_load.rem[j]   = num_mag[j][q2e_pkg::REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_pipe[0].valid <= 1'b0;
    end else if (en) begin
      div_pipe[0] <= div_load;
    end
  end

  // first cell takes the top quotient bit without shifting
  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    q2e_div_cell #(
      .SHIFT_IN (g != 0)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (div_pipe[g]),
      .dout (div_pipe[g+1])
    );
  end

  // ---------------- signed ratios ----------------
  q2e_pkg::div_t      div_out;
  logic               r_valid;
  logic               r_degen;
  logic signed [31:0] r_q [q2e_pkg::NUM_RATIOS];
  logic signed [31:0] q_next [q2e_pkg::NUM_RATIOS];
  logic [31:0]        q_mag [q2e_pkg::NUM_RATIOS];

  assign div_out = div_pipe[DIV_CELLS];

  always_comb begin
    for (int j = 0; j < q2e_pkg::NUM_RATIOS; j++) begin
      q_mag[j]  = {1'b0, div_out.quo[j]};
      q_next[j] = div_out.neg[j] ? $signed(-q_mag[j]) : $signed(q_mag[j]);
    end
    if (q_next[q2e_pkg::RAT_SIN_N] > q2e_pkg::ONE_Q30) begin
      q_next[q2e_pkg::RAT_SIN_N] = q2e_pkg::ONE_Q30;
    end else if (q_next[q2e_pkg::RAT_SIN_N] < -q2e_pkg::ONE_Q30) begin
      q_next[q2e_pkg::RAT_SIN_N] = -q2e_pkg::ONE_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= div_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_degen <= (div_out.s == '0);
      for (int j = 0; j < q2e_pkg::NUM_RATIOS; j++) begin
        r_q[j] <= q_next[j];
      end
    end
  end

  // ---------------- square of the asin term ----------------
  logic               t_valid;
  logic               t_degen;
  logic signed [31:0] t_q [q2e_pkg::NUM_RATIOS];
  logic signed [63:0] t_sq_full;
  logic [q2e_pkg::RAD_W-1:0] t_sq;

  assign t_sq_full = r_q[q2e_pkg::RAT_SIN_N] * r_q[q2e_pkg::RAT_SIN_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (en) begin
      t_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_degen <= r_degen;
      t_sq    <= t_sq_full[q2e_pkg::RAD_W-1:0];
      for (int j = 0; j < q2e_pkg::NUM_RATIOS; j++) begin
        t_q[j] <= r_q[j];
      end
    end
  end

  // ---------------- radicand, load square root ----------------
  q2e_pkg::sqrt_t sqrt_pipe [SQRT_CELLS+1];
  q2e_pkg::sqrt_t sqrt_load;

  always_comb begin
    sqrt_load.valid = t_valid;
    sqrt_load.degen = t_degen;
    sqrt_load.yaw_y = t_q[q2e_pkg::RAT_YAW_N];
    sqrt_load.yaw_x = t_q[q2e_pkg::RAT_YAW_D];
    sqrt_load.tan_y = t_q[q2e_pkg::RAT_TAN_N];
    sqrt_load.tan_x = t_q[q2e_pkg::RAT_TAN_D];
    sqrt_load.sin_t = t_q[q2e_pkg::RAT_SIN_N];
    sqrt_load.rem   = {1'b1, {(q2e_pkg::RAD_W-1){1'b0}}} - t_sq;
    sqrt_load.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_pipe[0].valid <= 1'b0;
    end else if (en) begin
      sqrt_pipe[0] <= sqrt_load;
    end
  end

  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
    q2e_sqrt_cell #(
      .K (SQRT_CELLS - 1 - g)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (sqrt_pipe[g]),
      .dout (sqrt_pipe[g+1])
    );
  end

  // ---------------- quadrant pre-rotation ----------------
  q2e_pkg::sqrt_t   sqrt_out;
  q2e_pkg::cordic_t cordic_pipe [CORDIC_STAGES+1];
  q2e_pkg::cordic_t cordic_load;
  logic signed [q2e_pkg::VEC_W-1:0] px [q2e_pkg::NUM_VECS];
  logic signed [q2e_pkg::VEC_W-1:0] py [q2e_pkg::NUM_VECS];

  assign sqrt_out = sqrt_pipe[SQRT_CELLS];

  always_comb begin
    px[q2e_pkg::VEC_YAW] = q2e_pkg::VEC_W'(sqrt_out.yaw_x);
    py[q2e_pkg::VEC_YAW] = q2e_pkg::VEC_W'(sqrt_out.yaw_y);
    px[q2e_pkg::VEC_TAN] = q2e_pkg::VEC_W'(sqrt_out.tan_x);
    py[q2e_pkg::VEC_TAN] = q2e_pkg::VEC_W'(sqrt_out.tan_y);
    px[q2e_pkg::VEC_SIN] = $signed(q2e_pkg::VEC_W'(sqrt_out.root));
    py[q2e_pkg::VEC_SIN] = q2e_pkg::VEC_W'(sqrt_out.sin_t);
    cordic_load.valid = sqrt_out.valid;
    cordic_load.degen = sqrt_out.degen;
    for (int j = 0; j < q2e_pkg::NUM_VECS; j++) begin
      cordic_load.vec[j].zero = (px[j] == '0) && (py[j] == '0);
      if (px[j][q2e_pkg::VEC_W-1] && !py[j][q2e_pkg::VEC_W-1]) begin
        cordic_load.vec[j].x   = py[j];
        cordic_load.vec[j].y   = -px[j];
        cordic_load.vec[j].ang = q2e_pkg::ANG_QUARTER;
      end else if (px[j][q2e_pkg::VEC_W-1]) begin
        cordic_load.vec[j].x   = -py[j];
        cordic_load.vec[j].y   = px[j];
        cordic_load.vec[j].ang = -q2e_pkg::ANG_QUARTER;
      end else begin
        cordic_load.vec[j].x   = px[j];
        cordic_load.vec[j].y   = py[j];
        cordic_load.vec[j].ang = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cordic_pipe[0].valid <= 1'b0;
    end else if (en) begin
      cordic_pipe[0] <= cordic_load;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    q2e_cordic_cell #(
      .I (g)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (cordic_pipe[g]),
      .dout (cordic_pipe[g+1])
    );
  end

  // ---------------- tenths, axis select, output register ----------------
  q2e_pkg::cordic_t   cordic_out;
  logic signed [11:0] tenths [q2e_pkg::NUM_VECS];
  logic signed [12:0] heading_s;
  logic signed [11:0] pitch_sel;
  logic signed [11:0] roll_sel;
  logic [11:0]        heading_next;
  logic signed [11:0] pitch_next;
  logic signed [11:0] roll_next;
  logic [11:0]        heading_tenths;
  logic signed [11:0] pitch_tenths;
  logic signed [11:0] roll_tenths;
  logic               degenerate;

  assign cordic_out = cordic_pipe[CORDIC_STAGES];

  always_comb begin
    for (int j = 0; j < q2e_pkg::NUM_VECS; j++) begin
      tenths[j] = cordic_out.vec[j].zero ? 12'sd0 : q2e_pkg::to_tenths(cordic_out.vec[j].ang);
    end
    heading_s = -13'(tenths[q2e_pkg::VEC_YAW]);
    if (heading_s[12]) begin
      heading_s = heading_s + q2e_pkg::HEADING_WRAP;
    end
    if (use_y_axis) begin
      roll_sel  = tenths[q2e_pkg::VEC_SIN];
      pitch_sel = tenths[q2e_pkg::VEC_TAN];
    end else begin
      pitch_sel = tenths[q2e_pkg::VEC_SIN];
      roll_sel  = tenths[q2e_pkg::VEC_TAN];
    end
    if (cordic_out.degen) begin
      heading_next = '0;
      pitch_next   = '0;
      roll_next    = '0;
    end else begin
      heading_next = heading_s[11:0];
      pitch_next   = pitch_sel;
      roll_next    = invert_roll ? -roll_sel : roll_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= cordic_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading_tenths <= heading_next;
      pitch_tenths   <= pitch_next;
      roll_tenths    <= roll_next;
      degenerate     <= cordic_out.degen;
    end
  end

  assign m_axis_tdata = {4'b0, roll_tenths, pitch_tenths, heading_tenths};
  assign m_axis_tuser = degenerate;

  // ---------------- assertions ----------------
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && degenerate |-> heading_tenths == '0 && pitch_tenths == '0 &&
      roll_tenths == '0)
    else $error("degenerate result carries nonzero angles");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> heading_tenths < 12'd3600)
    else $error("heading out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pitch_tenths <= q2e_pkg::TENTHS_MAX &&
      pitch_tenths >= -q2e_pkg::TENTHS_MAX)
    else $error("pitch out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(cordic_pipe[0]) && $stable(div_pipe[0].valid))
    else $error("pipeline moved during a stall");

endmodule
